[src/cobs_dfr_pkg.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_pkg
// shared constants, types and the crc-8 step for the cobs packet deframer
// ----------------------------------------------------------------------------
package cobs_dfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;
  localparam int unsigned FRAME_CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned BODY_CNT_W      = FRAME_CNT_W;
  localparam int unsigned TRAILER_LEN     = 4;
  localparam int unsigned PLEN_W          = 12;

  localparam logic [7:0] CRC_POLY       = 8'hB2;
  localparam logic [7:0] CRC_XOR_OUT    = 8'hFF;
  localparam logic [7:0] COBS_DELIM     = 8'h00;
  localparam logic [7:0] COBS_FULL_CODE = 8'hFF;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_CUT_GROUP  = 3'd1,
    STS_SHORT      = 3'd2,
    STS_LENGTH_BAD = 3'd3,
    STS_CRC_BAD    = 3'd4,
    STS_OVERLONG   = 3'd5
  } frame_status_e;

  typedef struct packed {
    logic          valid;
    logic [7:0]    data;
  } rx_stage_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              frame_end;
    frame_status_e     frame_status;
    logic [7:0]        packet_id;
    logic [7:0]        device_id;
    logic [PLEN_W-1:0] payload_length;
  } dfr_result_t;

  // reflected crc-8 over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

[src/cobs_dfr_rx_if.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_rx_if
// raw received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cobs_dfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/cobs_dfr_res_if.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_res_if
// deframed result channel: payload bytes and end-of-frame transactions
// ----------------------------------------------------------------------------
interface cobs_dfr_res_if;
  import cobs_dfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [7:0]        payload_byte;
  logic              frame_end;
  logic [2:0]        frame_status;
  logic [7:0]        packet_id;
  logic [7:0]        device_id;
  logic [PLEN_W-1:0] payload_length;

  modport source (
    output valid, output payload_byte, output frame_end, output frame_status,
    output packet_id, output device_id, output payload_length, input ready
  );
  modport sink (
    input valid, input payload_byte, input frame_end, input frame_status,
    input packet_id, input device_id, input payload_length, output ready
  );
endinterface

[src/cobs_crc8_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// cobs_crc8_packet_deframer_unit
// cobs deframer with crc-8 check: payload bytes out, one end transaction per
// non-empty frame carrying status, id, device and payload length
// path: an accepted byte is held in the input register, then its result in the result register
// throughput: one byte per cycle while the output is not stalled, set by the input register and result register
// a byte that gives no result still passes through the input register
// reset: rst_ni clears frame state and both valid flags; delay line unreset
// ----------------------------------------------------------------------------
module cobs_crc8_packet_deframer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  cobs_dfr_rx_if.sink    rx_i,
  cobs_dfr_res_if.source res_o
);
  import cobs_dfr_pkg::*;

  rx_stage_t stage;
  logic      advance;

  cobs_dfr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  cobs_dfr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .res_o     (res_o)
  );
endmodule

[src/cobs_dfr_in_stage.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_in_stage
// input register for received bytes, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module cobs_dfr_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  cobs_dfr_rx_if.sink             rx_i,
  input  logic                    advance_i,
  output cobs_dfr_pkg::rx_stage_t stage_o
);
  import cobs_dfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       accept;

  assign rx_i.ready = !valid_q || advance_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (accept) begin
      valid_d = 1'b1;
      data_d  = rx_i.rx_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;
endmodule

[src/cobs_dfr_core.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_core
// cobs decode, body delay line, lagging crc-8 and frame checks, with the
// result register that drives the output channel
// ----------------------------------------------------------------------------
module cobs_dfr_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cobs_dfr_pkg::rx_stage_t stage_i,
  output logic                    advance_o,
  cobs_dfr_res_if.source          res_o
);
  import cobs_dfr_pkg::*;

  // frame state
  logic                  started_q, started_d;
  logic [7:0]            group_left_q, group_left_d;
  logic                  was_full_q, was_full_d;
  logic [BODY_CNT_W-1:0] body_count_q, body_count_d;
  logic [7:0]            crc_q, crc_d;
  logic [FRAME_CNT_W-1:0] frame_bytes_q, frame_bytes_d;
  logic                  overlong_q, overlong_d;
  logic [7:0]            delay_q [4];
  logic [7:0]            delay_d [4];

  // result register
  logic                  out_valid_q, out_valid_d;
  dfr_result_t           out_q, out_d;

  logic                  fire;
  logic                  produce;
  logic                  is_code;
  logic                  do_push;
  logic [7:0]            push_val;
  frame_status_e         status;
  logic [7:0]            b;

  assign advance_o = !out_valid_q || res_o.ready;
  assign fire      = stage_i.valid && advance_o;
  assign b         = stage_i.data;

  always_comb begin
    if (overlong_q) begin
      status = STS_OVERLONG;
    end else if (group_left_q != 8'd0) begin
      status = STS_CUT_GROUP;
    end else if (body_count_q < BODY_CNT_W'(TRAILER_LEN)) begin
      status = STS_SHORT;
    end else if (delay_q[1] != 8'(body_count_q)) begin
      status = STS_LENGTH_BAD;
    end else if ((crc_q ^ CRC_XOR_OUT) != delay_q[0]) begin
      status = STS_CRC_BAD;
    end else begin
      status = STS_OK;
    end
  end

  always_comb begin
    started_d     = started_q;
    group_left_d  = group_left_q;
    was_full_d    = was_full_q;
    body_count_d  = body_count_q;
    crc_d         = crc_q;
    frame_bytes_d = frame_bytes_q;
    overlong_d    = overlong_q;
    delay_d       = delay_q;
    produce       = 1'b0;
    is_code       = 1'b0;
    do_push       = 1'b0;
    push_val      = 8'd0;
    out_d         = out_q;

    if (fire) begin
      if (b == COBS_DELIM) begin
        if (started_q) begin
          produce              = 1'b1;
          out_d.payload_byte   = 8'd0;
          out_d.frame_end      = 1'b1;
          out_d.frame_status   = status;
          out_d.packet_id      = (status == STS_OK) ? delay_q[3] : 8'd0;
          out_d.device_id      = (status == STS_OK) ? delay_q[2] : 8'd0;
          out_d.payload_length = (body_count_q > BODY_CNT_W'(TRAILER_LEN)) ?
                                 PLEN_W'(body_count_q - BODY_CNT_W'(TRAILER_LEN)) :
                                 PLEN_W'(0);
        end
        started_d     = 1'b0;
        group_left_d  = 8'd0;
        was_full_d    = 1'b0;
        body_count_d  = '0;
        crc_d         = 8'd0;
        frame_bytes_d = '0;
        overlong_d    = 1'b0;
      end else if (frame_bytes_q >= FRAME_CNT_W'(MAX_FRAME_BYTES)) begin
        overlong_d = 1'b1;
      end else begin
        frame_bytes_d = frame_bytes_q + FRAME_CNT_W'(1);
        if (!overlong_q) begin
          is_code = !started_q || (group_left_q == 8'd0);
          if (is_code) begin
            do_push      = started_q && !was_full_q;
            push_val     = 8'd0;
            started_d    = 1'b1;
            group_left_d = b - 8'd1;
            was_full_d   = (b == COBS_FULL_CODE);
          end else begin
            do_push      = 1'b1;
            push_val     = b;
            group_left_d = group_left_q - 8'd1;
          end
        end
      end

      if (do_push) begin
        if (body_count_q >= BODY_CNT_W'(TRAILER_LEN)) begin
          produce              = 1'b1;
          out_d.payload_byte   = delay_q[3];
          out_d.frame_end      = 1'b0;
          out_d.frame_status   = STS_OK;
          out_d.packet_id      = 8'd0;
          out_d.device_id      = 8'd0;
          out_d.payload_length = '0;
        end
        if (body_count_q != '0) begin
          crc_d = crc8_update(crc_q, delay_q[0]);
        end
        delay_d[3] = delay_q[2];
        delay_d[2] = delay_q[1];
        delay_d[1] = delay_q[0];
        delay_d[0] = push_val;
        if (body_count_q != '1) begin
          body_count_d = body_count_q + BODY_CNT_W'(1);
        end
      end
    end

    if (produce) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      group_left_q  <= 8'd0;
      was_full_q    <= 1'b0;
      body_count_q  <= '0;
      crc_q         <= 8'd0;
      frame_bytes_q <= '0;
      overlong_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      started_q     <= started_d;
      group_left_q  <= group_left_d;
      was_full_q    <= was_full_d;
      body_count_q  <= body_count_d;
      crc_q         <= crc_d;
      frame_bytes_q <= frame_bytes_d;
      overlong_q    <= overlong_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q <= delay_d;
    out_q   <= out_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.payload_byte   = out_q.payload_byte;
  assign res_o.frame_end      = out_q.frame_end;
  assign res_o.frame_status   = out_q.frame_status;
  assign res_o.packet_id      = out_q.packet_id;
  assign res_o.device_id      = out_q.device_id;
  assign res_o.payload_length = out_q.payload_length;
endmodule

[src/cobs_dfr_checker.sv]
// ----------------------------------------------------------------------------
// cobs_dfr_checker
// port-level checks on the deframer output transactions
// ----------------------------------------------------------------------------
module cobs_dfr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [7:0]        payload_byte_i,
  input logic              frame_end_i,
  input logic [2:0]        frame_status_i,
  input logic [7:0]        packet_id_i,
  input logic [7:0]        device_id_i,
  input logic [cobs_dfr_pkg::PLEN_W-1:0] payload_length_i
);
  import cobs_dfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i) &&
    $stable(frame_end_i) && $stable(frame_status_i) && $stable(payload_length_i))
    else $error("output transaction changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_end_i |-> frame_status_i == STS_OK && packet_id_i == 8'd0 &&
    device_id_i == 8'd0 && payload_length_i == '0)
    else $error("payload transaction carries end fields");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> payload_byte_i == 8'd0)
    else $error("end transaction carries a payload byte");

  a_bad_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i && frame_status_i != STS_OK |->
    packet_id_i == 8'd0 && device_id_i == 8'd0)
    else $error("bad frame reports ids");

  a_end_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> frame_status_i <= STS_OVERLONG &&
    payload_length_i <= PLEN_W'(MAX_FRAME_BYTES - TRAILER_LEN - 1))
    else $error("end transaction status or length out of range");
endmodule

bind cobs_crc8_packet_deframer_unit cobs_dfr_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .payload_byte_i   (res_o.payload_byte),
  .frame_end_i      (res_o.frame_end),
  .frame_status_i   (res_o.frame_status),
  .packet_id_i      (res_o.packet_id),
  .device_id_i      (res_o.device_id),
  .payload_length_i (res_o.payload_length)
);
